@@ hw/rtl/mrdr_pkg.sv @@
`timescale 1ns / 1ps

package mrdr_pkg;

  // Index width and stage limit of the generator.
  localparam int INDEX_BITS = 16;
  localparam int MAX_STAGES = 6;

  // Fixed register layout.
  localparam int RADIX_REGS = 6;
  localparam int RADIX_W    = 7;
  localparam int PC_W       = 17;
  localparam int SC_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Digit stages that exist in hardware.
  localparam int ACT_STAGES = (MAX_STAGES < RADIX_REGS) ? MAX_STAGES : RADIX_REGS;

  // Divider: quotient bits resolved between two registers.
  localparam int STEPS_PER_REG = 4;
  localparam int DIV_REGS      = (INDEX_BITS + STEPS_PER_REG - 1) / STEPS_PER_REG;

  // Stream widths, padded to whole bytes.
  localparam int DATA_W = ((INDEX_BITS + 7) / 8) * 8;

  // Width that holds both a position and the point count.
  localparam int CMP_W = (INDEX_BITS + 1 > PC_W) ? INDEX_BITS + 1 : PC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT = 3'd0,
    REG_STAGE_COUNT = 3'd1,
    REG_RADIX_0     = 3'd2,
    REG_RADIX_1     = 3'd3,
    REG_RADIX_2     = 3'd4,
    REG_RADIX_3     = 3'd5,
    REG_RADIX_4     = 3'd6,
    REG_RADIX_5     = 3'd7
  } reg_idx_e;

  // Settings as the datapath sees them: one radix per stage, 1 where idle.
  typedef struct packed {
    logic [PC_W-1:0]                       point_count;
    logic [ACT_STAGES-1:0][RADIX_W-1:0]    radix;
  } cfg_t;

  // One index in flight.
  typedef struct packed {
    logic                  oor;   // position not below point count
    logic [INDEX_BITS-1:0] pos;   // original position
    logic [INDEX_BITS-1:0] quo;   // position divided by radices so far
    logic [INDEX_BITS-1:0] racc;  // reversed digits, wrapped
    logic [INDEX_BITS-1:0] bacc;  // block size so far, wrapped
  } item_t;

endpackage

@@ hw/rtl/mrdr_cfg.sv @@
`timescale 1ns / 1ps

module mrdr_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mrdr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mrdr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output mrdr_pkg::cfg_t                  cfg_o
);
  import mrdr_pkg::*;

  logic [PC_W-1:0]                   point_count_q;
  logic [SC_W-1:0]                   stage_count_q;
  logic [RADIX_REGS-1:0][RADIX_W-1:0] radix_q;
  logic [RADIX_W-1:0]                new_radix;

  assign new_radix = cfg_data_i[RADIX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= PC_W'(2);
      stage_count_q <= SC_W'(1);
      for (int i = 0; i < RADIX_REGS; i++) begin
        radix_q[i] <= RADIX_W'(2);
      end
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_POINT_COUNT: point_count_q <= cfg_data_i[PC_W-1:0];
        REG_STAGE_COUNT: stage_count_q <= cfg_data_i[SC_W-1:0];
        REG_RADIX_0:     radix_q[0]    <= new_radix;
        REG_RADIX_1:     radix_q[1]    <= new_radix;
        REG_RADIX_2:     radix_q[2]    <= new_radix;
        REG_RADIX_3:     radix_q[3]    <= new_radix;
        REG_RADIX_4:     radix_q[4]    <= new_radix;
        REG_RADIX_5:     radix_q[5]    <= new_radix;
      endcase
    end
  end

  // Stages past the stage count, and radices below two, act as radix one.
  always_comb begin
    cfg_o.point_count = point_count_q;
    for (int t = 0; t < ACT_STAGES; t++) begin
      if ((stage_count_q > SC_W'(t)) && (radix_q[t] >= RADIX_W'(2))) begin
        cfg_o.radix[t] = radix_q[t];
      end else begin
        cfg_o.radix[t] = RADIX_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/mrdr_digit.sv @@
`timescale 1ns / 1ps

module mrdr_digit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [mrdr_pkg::RADIX_W-1:0] radix_i,
  input  logic                         valid_i,
  input  mrdr_pkg::item_t              item_i,
  output logic                         valid_o,
  output mrdr_pkg::item_t              item_o
);
  import mrdr_pkg::*;

  localparam int MAC_W = INDEX_BITS + RADIX_W;

  typedef struct packed {
    item_t              item;
    logic [RADIX_W-1:0] rem;
  } div_t;

  div_t                div_d [DIV_REGS];
  div_t                div_q [DIV_REGS];
  logic [DIV_REGS-1:0] div_vld_q;
  item_t               mac_d, mac_q;
  logic                mac_vld_q;
  logic [MAC_W-1:0]    racc_w, bacc_w;

  // Restoring division, four quotient bits per register.
  always_comb begin
    div_t              cur;
    logic [RADIX_W:0]  trial;
    for (int g = 0; g < DIV_REGS; g++) begin
      if (g == 0) begin
        cur.item = item_i;
        cur.rem  = '0;
      end else begin
        cur = div_q[g-1];
      end
      for (int j = 0; j < STEPS_PER_REG; j++) begin
        if (g * STEPS_PER_REG + j < INDEX_BITS) begin
          trial = {cur.rem, cur.item.quo[INDEX_BITS-1]};
          if (trial >= {1'b0, radix_i}) begin
            cur.rem      = RADIX_W'(trial - {1'b0, radix_i});
            cur.item.quo = {cur.item.quo[INDEX_BITS-2:0], 1'b1};
          end else begin
            cur.rem      = trial[RADIX_W-1:0];
            cur.item.quo = {cur.item.quo[INDEX_BITS-2:0], 1'b0};
          end
        end
      end
      div_d[g] = cur;
    end
  end

  // Append the digit to the reversed index and grow the block size.
  always_comb begin
    racc_w = MAC_W'(div_q[DIV_REGS-1].item.racc) * MAC_W'(radix_i)
           + MAC_W'(div_q[DIV_REGS-1].rem);
    bacc_w = MAC_W'(div_q[DIV_REGS-1].item.bacc) * MAC_W'(radix_i);
    mac_d      = div_q[DIV_REGS-1].item;
    mac_d.racc = racc_w[INDEX_BITS-1:0];
    mac_d.bacc = bacc_w[INDEX_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q <= '0;
      mac_vld_q <= 1'b0;
    end else if (en_i) begin
      div_vld_q <= {div_vld_q[DIV_REGS-2:0], valid_i};
      mac_vld_q <= div_vld_q[DIV_REGS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
      mac_q <= mac_d;
    end
  end

  assign valid_o = mac_vld_q;
  assign item_o  = mac_q;

endmodule

@@ hw/rtl/mrdr_merge.sv @@
`timescale 1ns / 1ps

module mrdr_merge (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  mrdr_pkg::item_t                 item_i,
  output logic                            valid_o,
  output logic [mrdr_pkg::INDEX_BITS-1:0] source_index_o,
  output logic                            out_of_range_o
);
  import mrdr_pkg::*;

  logic [2*INDEX_BITS-1:0] prod_w;
  logic [INDEX_BITS-1:0]   prod_q, racc_q, pos_q;
  logic [INDEX_BITS-1:0]   sum_w;
  logic                    oor_q, vld_a_q;
  logic [INDEX_BITS-1:0]   src_q;
  logic                    src_oor_q, src_vld_q;

  // Upper part of the index: quotient times full block size.
  assign prod_w = (2*INDEX_BITS)'(item_i.quo) * (2*INDEX_BITS)'(item_i.bacc);
  assign sum_w  = prod_q + racc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= 1'b0;
      src_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q   <= valid_i;
      src_vld_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= prod_w[INDEX_BITS-1:0];
      racc_q    <= item_i.racc;
      pos_q     <= item_i.pos;
      oor_q     <= item_i.oor;
      src_q     <= oor_q ? pos_q : sum_w;
      src_oor_q <= oor_q;
    end
  end

  assign valid_o        = src_vld_q;
  assign source_index_o = src_q;
  assign out_of_range_o = src_oor_q;

endmodule

@@ hw/rtl/mixed_radix_digit_reversal_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Beat contents (tdata / tuser, lowest bit first)
// s_axis    in         tdata: position
// m_axis    out        tdata: source_index            tuser: out_of_range
// cfg       in         one register write per cycle with cfg_we_i high
//
// One index enters per cycle while the output is not stalled. Each digit
// stage has a divider of four registers, four quotient bits per register,
// then a multiply-add that appends the digit.
// Reset clears every valid bit and loads the default settings at once.
// A stalled output holds the whole pipeline; no beat is lost or repeated.
module mixed_radix_digit_reversal_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mrdr_pkg::DATA_W-1:0]     s_axis_tdata,   // position
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mrdr_pkg::DATA_W-1:0]     m_axis_tdata,   // source_index
  output logic                            m_axis_tuser,   // out_of_range
  // register writes
  input  logic                            cfg_we_i,
  input  logic [mrdr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mrdr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mrdr_pkg::*;

  cfg_t                  cfg;
  logic                  en;
  logic                  in_vld_q;
  item_t                 in_d, in_q;
  logic [INDEX_BITS-1:0] pos;

  logic                  stg_vld [ACT_STAGES+1];
  item_t                 stg_item [ACT_STAGES+1];

  logic                  out_vld;
  logic [INDEX_BITS-1:0] out_index;
  logic                  out_oor;

  mrdr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance everything whenever the output register is free or drained.
  assign en            = !out_vld || m_axis_tready;
  assign s_axis_tready = en;

  // Flag out-of-range positions up front; the index math runs on them
  // anyway and the merge stage swaps the position back in.
  assign pos = s_axis_tdata[INDEX_BITS-1:0];
  always_comb begin
    in_d.pos  = pos;
    in_d.quo  = pos;
    in_d.racc = '0;
    in_d.bacc = INDEX_BITS'(1);
    in_d.oor  = (CMP_W'(pos) >= CMP_W'(cfg.point_count));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_d;
    end
  end

  assign stg_vld[0]  = in_vld_q;
  assign stg_item[0] = in_q;

  // One stage per radix: peel the next digit off the quotient and push it
  // onto the reversed index (digit-reversal in closed form).
  for (genvar t = 0; t < ACT_STAGES; t++) begin : g_digit
    mrdr_digit u_digit (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .radix_i (cfg.radix[t]),
      .valid_i (stg_vld[t]),
      .item_i  (stg_item[t]),
      .valid_o (stg_vld[t+1]),
      .item_o  (stg_item[t+1])
    );
  end

  mrdr_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (stg_vld[ACT_STAGES]),
    .item_i         (stg_item[ACT_STAGES]),
    .valid_o        (out_vld),
    .source_index_o (out_index),
    .out_of_range_o (out_oor)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = DATA_W'(out_index);
  assign m_axis_tuser  = out_oor;

endmodule
